/* hw/rtl/ddoi_pkg.sv */
// Types, constants and microcode program for the odometry integrator.
`default_nettype none

package ddoi_pkg;

	localparam int ITER_W = 5;

	localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
	localparam logic signed [32:0] HEAD_PER_RAD    = 33'sd341782638;
	localparam logic        [15:0] TIME_STEP_RESET = 16'd655;

	localparam logic signed [65:0] SAT_MAX  = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN  = -66'sd2147483648;
	localparam logic signed [33:0] UNIT_MAX = 34'sd1073741824;
	localparam logic signed [33:0] UNIT_MIN = -34'sd1073741824;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_CORD1  = 4'd1;
	localparam step_t STEP_TRIG1  = 4'd2;
	localparam step_t STEP_MULC   = 4'd3;
	localparam step_t STEP_MULS   = 4'd4;
	localparam step_t STEP_MULVX  = 4'd5;
	localparam step_t STEP_MULVY  = 4'd6;
	localparam step_t STEP_MULOM  = 4'd7;
	localparam step_t STEP_MULLO  = 4'd8;
	localparam step_t STEP_MULHI  = 4'd9;
	localparam step_t STEP_HEAD   = 4'd10;
	localparam step_t STEP_INIT2  = 4'd11;
	localparam step_t STEP_CORD2  = 4'd12;
	localparam step_t STEP_TRIG2  = 4'd13;
	localparam step_t STEP_OUT    = 4'd14;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_LIN_C,
		MUL_LIN_S,
		MUL_VX_DT,
		MUL_VY_DT,
		MUL_OM_DT,
		MUL_LO_K,
		MUL_HI_K
	} mul_op_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_IN,
		WR_TRIG,
		WR_VX,
		WR_VY,
		WR_PX,
		WR_PY,
		WR_OMDT,
		WR_ACC,
		WR_HEAD,
		WR_OUT
	} wr_op_t;

	typedef enum logic [1:0] {
		COR_NONE,
		COR_INIT_OLD,
		COR_INIT_NEW,
		COR_STEP
	} cor_op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_IN,
		HOLD_COR,
		HOLD_OUT
	} hold_t;

	typedef struct packed {
		mul_op_t mul;
		wr_op_t  wr;
		cor_op_t cor;
		hold_t   hold;
		step_t   next;
	} uword_t;

	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < SAT_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > UNIT_MAX)
			r = 32'sd1073741824;
		else if (v < UNIT_MIN)
			r = -32'sd1073741824;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		case (pc)
			STEP_IDLE:  w = '{mul: MUL_NONE,  wr: WR_IN,   cor: COR_INIT_OLD,
				hold: HOLD_IN,   next: STEP_CORD1};
			STEP_CORD1: w = '{mul: MUL_NONE,  wr: WR_NONE, cor: COR_STEP,
				hold: HOLD_COR,  next: STEP_TRIG1};
			STEP_TRIG1: w = '{mul: MUL_NONE,  wr: WR_TRIG, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULC};
			STEP_MULC:  w = '{mul: MUL_LIN_C, wr: WR_NONE, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULS};
			STEP_MULS:  w = '{mul: MUL_LIN_S, wr: WR_VX,   cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULVX};
			STEP_MULVX: w = '{mul: MUL_VX_DT, wr: WR_VY,   cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULVY};
			STEP_MULVY: w = '{mul: MUL_VY_DT, wr: WR_PX,   cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULOM};
			STEP_MULOM: w = '{mul: MUL_OM_DT, wr: WR_PY,   cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULLO};
			STEP_MULLO: w = '{mul: MUL_LO_K,  wr: WR_OMDT, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_MULHI};
			STEP_MULHI: w = '{mul: MUL_HI_K,  wr: WR_ACC,  cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_HEAD};
			STEP_HEAD:  w = '{mul: MUL_NONE,  wr: WR_HEAD, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_INIT2};
			STEP_INIT2: w = '{mul: MUL_NONE,  wr: WR_NONE, cor: COR_INIT_NEW,
				hold: HOLD_NONE, next: STEP_CORD2};
			STEP_CORD2: w = '{mul: MUL_NONE,  wr: WR_NONE, cor: COR_STEP,
				hold: HOLD_COR,  next: STEP_TRIG2};
			STEP_TRIG2: w = '{mul: MUL_NONE,  wr: WR_TRIG, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_OUT};
			STEP_OUT:   w = '{mul: MUL_NONE,  wr: WR_OUT,  cor: COR_NONE,
				hold: HOLD_OUT,  next: STEP_IDLE};
			default:    w = '{mul: MUL_NONE,  wr: WR_NONE, cor: COR_NONE,
				hold: HOLD_NONE, next: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/diff_drive_odometry_integrator.sv */
// Differential-drive odometry integrator: microcoded CORDIC and multiply datapath.
//
// Input channel (in_valid/in_ready) takes left_speed and right_speed, signed Q16.16.
// Output channel (out_valid/out_ready) gives velocity, yaw rate, position and the
// yaw quaternion of the new heading. One result item per input item.
// The user must write time_step through cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this. The work runs on one shared
// 33x33 multiplier and one iterative CORDIC, driven by a 15-step microcode program.
// The CORDIC runs twice per item at one iteration per cycle. The next item is
// accepted in the cycle after the result is loaded.
// The result sits in its own register: if the receiver stalls, the next item is
// still taken and computed, and the program waits at its last step until the
// result register is free.
// Reset clears position and heading, sets time_step to 655 and empties the
// result register.
`default_nettype none

module diff_drive_odometry_integrator
	import ddoi_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic        [15:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_speed,
	input  logic signed [31:0] right_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	output logic signed [31:0] pos_x_out,
	output logic signed [31:0] pos_y_out,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_z
);

	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

	step_t               pc_q;
	uword_t              uw;
	logic                go;
	logic                out_valid_q;
	logic        [15:0]  ts_q;
	logic signed [31:0]  px_q, py_q;
	logic        [31:0]  head_q;

	logic signed [31:0]  lin_q, om_q, c_q, s_q, vx_q, vy_q;
	logic signed [65:0]  prod_q;
	logic        [48:0]  omdt_q;
	logic        [63:0]  acc_q;

	logic signed [33:0]  cx_q, cy_q;
	logic signed [32:0]  cz_q;
	logic        [1:0]   quad_q;
	logic [ITER_W-1:0]   iter_q;

	logic signed [32:0]  mul_a, mul_b;
	logic signed [32:0]  sum_in, dif_in;
	logic signed [65:0]  rnd_v, rnd_p, pos_sum;
	logic signed [31:0]  vel_next, pos_next;
	logic        [63:0]  head_sum;
	logic        [31:0]  ang, ang_adj, ang_d;
	logic        [1:0]   ang_q;
	logic signed [33:0]  xs, ys;
	logic signed [31:0]  xc, yc, c_next, s_next;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.hold)
			HOLD_NONE: go = 1'b1;
			HOLD_IN:   go = in_valid;
			HOLD_COR:  go = (iter_q == ITER_LAST);
			HOLD_OUT:  go = !out_valid_q || out_ready;
			default:   go = 1'b1;
		endcase
	end

	assign in_ready  = (uw.hold == HOLD_IN);
	assign out_valid = out_valid_q;

	// shared multiplier operands
	always_comb begin
		case (uw.mul)
			MUL_LIN_C: begin
				mul_a = 33'(lin_q);
				mul_b = 33'(c_q);
			end
			MUL_LIN_S: begin
				mul_a = 33'(lin_q);
				mul_b = 33'(s_q);
			end
			MUL_VX_DT: begin
				mul_a = 33'(vx_q);
				mul_b = {17'd0, ts_q};
			end
			MUL_VY_DT: begin
				mul_a = 33'(vy_q);
				mul_b = {17'd0, ts_q};
			end
			MUL_OM_DT: begin
				mul_a = 33'(om_q);
				mul_b = {17'd0, ts_q};
			end
			MUL_LO_K: begin
				mul_a = {9'd0, prod_q[23:0]};
				mul_b = HEAD_PER_RAD;
			end
			MUL_HI_K: begin
				mul_a = {{8{omdt_q[48]}}, omdt_q[48:24]};
				mul_b = HEAD_PER_RAD;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		sum_in   = 33'(left_speed) + 33'(right_speed);
		dif_in   = 33'(right_speed) - 33'(left_speed);
		rnd_v    = prod_q + (66'sd1 <<< 29);
		vel_next = sat32(rnd_v >>> 30);
		rnd_p    = prod_q + (66'sd1 <<< 15);
		pos_sum  = (rnd_p >>> 16) + 66'((uw.wr == WR_PX) ? px_q : py_q);
		pos_next = sat32(pos_sum);
		head_sum = acc_q + {prod_q[39:0], 24'd0};
	end

	// CORDIC angle reduction to the nearest quadrant
	always_comb begin
		ang     = (uw.cor == COR_INIT_OLD) ? {head_q[30:0], 1'b0} : head_q;
		ang_adj = ang + 32'h20000000;
		ang_q   = ang_adj[31:30];
		ang_d   = ang - {ang_q, 30'd0};
		xs      = cx_q >>> iter_q;
		ys      = cy_q >>> iter_q;
		xc      = clamp_unit(cx_q);
		yc      = clamp_unit(cy_q);
		case (quad_q)
			2'd1: begin
				c_next = -yc;
				s_next = xc;
			end
			2'd2: begin
				c_next = -xc;
				s_next = -yc;
			end
			2'd3: begin
				c_next = yc;
				s_next = -xc;
			end
			default: begin
				c_next = xc;
				s_next = yc;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			out_valid_q <= 1'b0;
			ts_q        <= TIME_STEP_RESET;
			px_q        <= '0;
			py_q        <= '0;
			head_q      <= '0;
			iter_q      <= '0;
		end else begin
			if (cfg_wr_en)
				ts_q <= cfg_wr_data;
			if (go)
				pc_q <= uw.next;
			if (go && uw.wr == WR_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (go && uw.wr == WR_PX)
				px_q <= pos_next;
			if (go && uw.wr == WR_PY)
				py_q <= pos_next;
			if (go && uw.wr == WR_HEAD)
				head_q <= head_q + head_sum[63:32];
			if (go && (uw.cor == COR_INIT_OLD || uw.cor == COR_INIT_NEW))
				iter_q <= '0;
			else if (uw.cor == COR_STEP)
				iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.mul != MUL_NONE)
			prod_q <= mul_a * mul_b;
		if (go) begin
			case (uw.wr)
				WR_IN: begin
					lin_q <= sum_in[32:1];
					om_q  <= dif_in[32:1];
				end
				WR_TRIG: begin
					c_q <= c_next;
					s_q <= s_next;
				end
				WR_VX:   vx_q   <= vel_next;
				WR_VY:   vy_q   <= vel_next;
				WR_OMDT: omdt_q <= prod_q[48:0];
				WR_ACC:  acc_q  <= prod_q[63:0] + 64'h0000_0000_8000_0000;
				WR_OUT: begin
					vel_x     <= vx_q;
					vel_y     <= vy_q;
					yaw_rate  <= om_q;
					pos_x_out <= px_q;
					pos_y_out <= py_q;
					quat_w    <= c_q;
					quat_z    <= s_q;
				end
				default: ;
			endcase
		end
		if (go && (uw.cor == COR_INIT_OLD || uw.cor == COR_INIT_NEW)) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= 33'(signed'(ang_d));
			quad_q <= ang_q;
		end else if (uw.cor == COR_STEP) begin
			if (!cz_q[32]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - signed'({1'b0, atan_turn(iter_q)});
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + signed'({1'b0, atan_turn(iter_q)});
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ddoi_chk.sv */
// Port-level checks for the odometry integrator, bound to the top level.
`default_nettype none

module ddoi_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] pos_x_out,
	input logic signed [31:0] quat_w,
	input logic signed [31:0] quat_z
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vel_x) && $stable(pos_x_out)
			&& $stable(quat_w) && $stable(quat_z))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824
			&& quat_z <= 32'sd1073741824 && quat_z >= -32'sd1073741824)
		else $error("quaternion out of unit range");

endmodule

bind diff_drive_odometry_integrator ddoi_chk u_ddoi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.vel_x     (vel_x),
	.pos_x_out (pos_x_out),
	.quat_w    (quat_w),
	.quat_z    (quat_z)
);

`default_nettype wire
